/* rtl/scc_pkg.sv */
// Shared constants for the strongly connected components block.
package scc_pkg;

	localparam int MAX_NODES_DEF = 64;
	localparam int NODE_W        = 7;
	localparam int COMP_W        = 6;
	localparam int REQ_W         = 2;

	localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_RUN   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

endpackage

/* rtl/scc_matrix.sv */
// Adjacency bit matrix: one row per node, synchronous read, per-row valid bits for fast clear.
module scc_matrix
	import scc_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF,
	localparam int IW = $clog2(MAX_NODES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clear,
	input  logic                 rd_en,
	input  logic [IW-1:0]        rd_addr,
	input  logic                 wr_en,
	input  logic [IW-1:0]        wr_addr,
	input  logic [MAX_NODES-1:0] wr_data,
	output logic [MAX_NODES-1:0] row
);

	logic [MAX_NODES-1:0] mem_q [MAX_NODES];
	logic [MAX_NODES-1:0] vld_q;
	logic [MAX_NODES-1:0] row_q;
	logic                 row_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			row_vld_q <= 1'b0;
		end else begin
			if (clear) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				row_vld_q <= vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			row_q <= mem_q[rd_addr];
		end
	end

	// rows never written since the last clear read as empty
	assign row = row_vld_q ? row_q : '0;

endmodule

/* rtl/strongly_connected_components.sv */
// Top level: Kosaraju strongly connected components over a small directed graph.
//
// Input channel (in_valid/in_ready) takes one request per transfer:
//   add edge  - sets edge_from->edge_to in the forward and reverse matrices;
//               edges naming a node outside 1..node_count are dropped.
//   clear     - empties both matrices through their per-row valid bits.
//   run       - forward depth-first pass builds a finish stack, then reverse
//               passes in pop order list each component. One result per node.
// Output channel (out_valid/out_ready) carries member_node, component_index,
// ends_component and last. Results leave through one output register, with one
// more result held back so its end-of-component flag is known before transfer.
// Every push or pop of a walk costs a matrix-memory read plus an evaluate step,
// and each pass touches every node once. The single read port of each matrix
// memory sets that pace. The reverse walk stops while the receiver stalls a
// full output register and resumes when that register frees.
// in_ready is high only while no request is in progress.
// Reset: both matrices read empty, node_count is 64, no result is pending.
// node_count is written through cfg_wr_en/cfg_wr_data; the user must write it only while idle,
// which the block does not enforce. Values above MAX_NODES act as MAX_NODES and zero makes a run give no results.
module strongly_connected_components
	import scc_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [NODE_W-1:0] cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [NODE_W-1:0] edge_from,
	input  logic [NODE_W-1:0] edge_to,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [NODE_W-1:0] member_node,
	output logic [COMP_W-1:0] component_index,
	output logic              ends_component,
	output logic              last
);

	localparam int IW = $clog2(MAX_NODES);
	localparam int DW = $clog2(MAX_NODES + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_EDGE_RD, ST_EDGE_WR,
		ST_F_SCAN, ST_F_READ, ST_F_EVAL, ST_F_POP,
		ST_R_POP, ST_R_TAKE, ST_R_CHK, ST_R_READ, ST_R_EVAL, ST_R_WPOP,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [NODE_W-1:0]    node_count_q;
	logic [MAX_NODES-1:0] visited_q;
	logic [NODE_W-1:0]    scan_q;
	logic [IW-1:0]        top_q, from_q, to_q, s_q;
	logic [DW-1:0]        depth_q, fc_q;
	logic [COMP_W-1:0]    comp_q;

	// held-back result and output register
	logic              pend_v_q, pend_end_q;
	logic [IW-1:0]     pend_node_q;
	logic [COMP_W-1:0] pend_comp_q;
	logic              out_v_q, out_end_q, out_last_q;
	logic [IW-1:0]     out_node_q;
	logic [COMP_W-1:0] out_comp_q;

	// stack memories
	logic [IW-1:0] walk_mem_q [MAX_NODES];
	logic [IW-1:0] fin_mem_q  [MAX_NODES];
	logic [IW-1:0] walk_rd_q, fin_rd_q;
	logic          walk_we, walk_re, fin_we, fin_re;
	logic [IW-1:0] walk_waddr, walk_wdata, walk_raddr, fin_waddr, fin_raddr;

	// matrix controls
	logic                 mat_clear, mat_re, fwd_we, rev_we;
	logic [IW-1:0]        fwd_raddr, rev_raddr;
	logic [MAX_NODES-1:0] fwd_wdata, rev_wdata, fwd_row, rev_row;

	logic [NODE_W-1:0]    used_n;
	logic [MAX_NODES-1:0] mask, cand;
	logic [IW-1:0]        j_idx, scan_idx;
	logic                 push, slot_free, can_emit, edge_ok;
	logic [NODE_W-1:0]    max_n;

	assign max_n  = NODE_W'(MAX_NODES);
	assign used_n = (node_count_q > max_n) ? max_n : node_count_q;

	always_comb begin
		for (int k = 0; k < MAX_NODES; k++) begin
			mask[k] = (NODE_W'(k) < used_n);
		end
	end

	assign cand = ((state_q == ST_R_EVAL) ? rev_row : fwd_row) & mask & ~visited_q;
	assign push = (cand != '0) && (depth_q < DW'(MAX_NODES));

	// lowest set candidate: neighbors are taken in ascending order
	always_comb begin
		j_idx = '0;
		for (int k = MAX_NODES - 1; k >= 0; k--) begin
			if (cand[k]) begin
				j_idx = IW'(k);
			end
		end
	end

	assign scan_idx  = scan_q[IW-1:0];
	assign slot_free = !out_v_q || out_ready;
	assign can_emit  = !pend_v_q || slot_free;
	assign edge_ok   = (edge_from != '0) && (edge_from <= used_n)
	                && (edge_to != '0) && (edge_to <= used_n);

	assign in_ready  = (state_q == ST_IDLE);
	assign mat_clear = (state_q == ST_IDLE) && in_valid && (req_type == REQ_CLEAR);

	// memory port controls
	always_comb begin
		mat_re     = 1'b0;
		fwd_raddr  = top_q;
		rev_raddr  = top_q;
		fwd_we     = 1'b0;
		rev_we     = 1'b0;
		fwd_wdata  = fwd_row | ({{(MAX_NODES-1){1'b0}}, 1'b1} << to_q);
		rev_wdata  = rev_row | ({{(MAX_NODES-1){1'b0}}, 1'b1} << from_q);
		walk_we    = 1'b0;
		walk_waddr = depth_q[IW-1:0];
		walk_wdata = j_idx;
		walk_re    = 1'b0;
		walk_raddr = IW'(depth_q - DW'(2));
		fin_we     = 1'b0;
		fin_waddr  = fc_q[IW-1:0];
		fin_re     = 1'b0;
		fin_raddr  = IW'(fc_q - DW'(1));
		unique case (state_q)
			ST_EDGE_RD: begin
				mat_re    = 1'b1;
				fwd_raddr = from_q;
				rev_raddr = to_q;
			end
			ST_EDGE_WR: begin
				fwd_we = 1'b1;
				rev_we = 1'b1;
			end
			ST_F_READ, ST_R_READ: begin
				mat_re = 1'b1;
			end
			ST_F_POP, ST_R_WPOP: begin
				mat_re    = 1'b1;
				fwd_raddr = walk_rd_q;
				rev_raddr = walk_rd_q;
			end
			ST_F_SCAN: begin
				if (scan_q < used_n && !visited_q[scan_idx]) begin
					walk_we    = 1'b1;
					walk_waddr = '0;
					walk_wdata = scan_idx;
				end
			end
			ST_F_EVAL: begin
				if (push) begin
					walk_we = 1'b1;
				end else begin
					fin_we  = (fc_q < DW'(MAX_NODES));
					walk_re = (depth_q != DW'(1));
				end
			end
			ST_R_POP: begin
				fin_re = (fc_q != '0);
			end
			ST_R_CHK: begin
				if (!visited_q[s_q] && can_emit) begin
					walk_we    = 1'b1;
					walk_waddr = '0;
					walk_wdata = s_q;
				end
			end
			ST_R_EVAL: begin
				if (push) begin
					walk_we = can_emit;
				end else begin
					walk_re = (depth_q != DW'(1));
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (walk_we) begin
			walk_mem_q[walk_waddr] <= walk_wdata;
		end
		if (walk_re) begin
			walk_rd_q <= walk_mem_q[walk_raddr];
		end
		if (fin_we) begin
			fin_mem_q[fin_waddr] <= top_q;
		end
		if (fin_re) begin
			fin_rd_q <= fin_mem_q[fin_raddr];
		end
	end

	scc_matrix #(.MAX_NODES(MAX_NODES)) u_fwd (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (mat_clear),
		.rd_en   (mat_re),
		.rd_addr (fwd_raddr),
		.wr_en   (fwd_we),
		.wr_addr (from_q),
		.wr_data (fwd_wdata),
		.row     (fwd_row)
	);

	scc_matrix #(.MAX_NODES(MAX_NODES)) u_rev (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (mat_clear),
		.rd_en   (mat_re),
		.rd_addr (rev_raddr),
		.wr_en   (rev_we),
		.wr_addr (to_q),
		.wr_data (rev_wdata),
		.row     (rev_row)
	);

	// sequencer, held-back result and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			node_count_q <= NODE_W'(MAX_NODES_DEF);
			visited_q    <= '0;
			scan_q       <= '0;
			top_q        <= '0;
			from_q       <= '0;
			to_q         <= '0;
			s_q          <= '0;
			depth_q      <= '0;
			fc_q         <= '0;
			comp_q       <= '0;
			pend_v_q     <= 1'b0;
			pend_end_q   <= 1'b0;
			pend_node_q  <= '0;
			pend_comp_q  <= '0;
			out_v_q      <= 1'b0;
			out_end_q    <= 1'b0;
			out_last_q   <= 1'b0;
			out_node_q   <= '0;
			out_comp_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				node_count_q <= cfg_wr_data;
			end
			if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (req_type == REQ_ADD && edge_ok) begin
							from_q  <= IW'(edge_from - NODE_W'(1));
							to_q    <= IW'(edge_to - NODE_W'(1));
							state_q <= ST_EDGE_RD;
						end else if (req_type == REQ_RUN) begin
							visited_q  <= '0;
							fc_q       <= '0;
							comp_q     <= '0;
							scan_q     <= '0;
							pend_v_q   <= 1'b0;
							pend_end_q <= 1'b0;
							state_q    <= ST_F_SCAN;
						end
					end
				end
				ST_EDGE_RD: state_q <= ST_EDGE_WR;
				ST_EDGE_WR: state_q <= ST_IDLE;
				ST_F_SCAN: begin
					if (scan_q >= used_n) begin
						visited_q <= '0;
						state_q   <= ST_R_POP;
					end else begin
						scan_q <= scan_q + NODE_W'(1);
						if (!visited_q[scan_idx]) begin
							visited_q[scan_idx] <= 1'b1;
							top_q   <= scan_idx;
							depth_q <= DW'(1);
							state_q <= ST_F_READ;
						end
					end
				end
				ST_F_READ: state_q <= ST_F_EVAL;
				ST_F_EVAL: begin
					if (push) begin
						visited_q[j_idx] <= 1'b1;
						depth_q <= depth_q + DW'(1);
						top_q   <= j_idx;
						state_q <= ST_F_READ;
					end else begin
						depth_q <= depth_q - DW'(1);
						if (fc_q < DW'(MAX_NODES)) begin
							fc_q <= fc_q + DW'(1);
						end
						state_q <= (depth_q == DW'(1)) ? ST_F_SCAN : ST_F_POP;
					end
				end
				ST_F_POP: begin
					top_q   <= walk_rd_q;
					state_q <= ST_F_EVAL;
				end
				ST_R_POP: begin
					if (fc_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						fc_q    <= fc_q - DW'(1);
						state_q <= ST_R_TAKE;
					end
				end
				ST_R_TAKE: begin
					s_q     <= fin_rd_q;
					state_q <= ST_R_CHK;
				end
				ST_R_CHK: begin
					if (visited_q[s_q]) begin
						state_q <= ST_R_POP;
					end else if (can_emit) begin
						visited_q[s_q] <= 1'b1;
						top_q   <= s_q;
						depth_q <= DW'(1);
						if (pend_v_q) begin
							out_v_q    <= 1'b1;
							out_node_q <= pend_node_q;
							out_comp_q <= pend_comp_q;
							out_end_q  <= pend_end_q;
							out_last_q <= 1'b0;
						end
						pend_v_q    <= 1'b1;
						pend_node_q <= s_q;
						pend_comp_q <= comp_q;
						pend_end_q  <= 1'b0;
						state_q     <= ST_R_READ;
					end
				end
				ST_R_READ: state_q <= ST_R_EVAL;
				ST_R_EVAL: begin
					if (push) begin
						if (can_emit) begin
							visited_q[j_idx] <= 1'b1;
							depth_q <= depth_q + DW'(1);
							top_q   <= j_idx;
							if (pend_v_q) begin
								out_v_q    <= 1'b1;
								out_node_q <= pend_node_q;
								out_comp_q <= pend_comp_q;
								out_end_q  <= pend_end_q;
								out_last_q <= 1'b0;
							end
							pend_v_q    <= 1'b1;
							pend_node_q <= j_idx;
							pend_comp_q <= comp_q;
							pend_end_q  <= 1'b0;
							state_q     <= ST_R_READ;
						end
					end else begin
						depth_q <= depth_q - DW'(1);
						if (depth_q == DW'(1)) begin
							pend_end_q <= 1'b1;
							comp_q     <= comp_q + COMP_W'(1);
							state_q    <= ST_R_POP;
						end else begin
							state_q <= ST_R_WPOP;
						end
					end
				end
				ST_R_WPOP: begin
					top_q   <= walk_rd_q;
					state_q <= ST_R_EVAL;
				end
				ST_DONE: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (slot_free) begin
						out_v_q    <= 1'b1;
						out_node_q <= pend_node_q;
						out_comp_q <= pend_comp_q;
						out_end_q  <= 1'b1;
						out_last_q <= 1'b1;
						pend_v_q   <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid       = out_v_q;
	assign member_node     = {{(NODE_W-IW){1'b0}}, out_node_q} + NODE_W'(1);
	assign component_index = out_comp_q;
	assign ends_component  = out_end_q;
	assign last            = out_last_q;

endmodule

/* rtl/scc_checker.sv */
// Port-level checks for the strongly connected components block, with its bind.
module scc_checker
	import scc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [REQ_W-1:0]  req_type,
	input logic              out_valid,
	input logic              out_ready,
	input logic [NODE_W-1:0] member_node,
	input logic              ends_component,
	input logic              last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(member_node) && $stable(last))
		else $error("result changed while stalled");

	a_node_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> member_node != '0)
		else $error("node number zero");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> ends_component)
		else $error("final result does not close its component");

	a_busy_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && req_type == REQ_RUN |=> !in_ready)
		else $error("request taken while a run is in progress");

endmodule

bind strongly_connected_components scc_checker u_scc_checker (.*);

/* test/tb_strongly_connected_components.sv */
// Testbench for the strongly connected components block: directed and random graphs.
module tb_strongly_connected_components;
	import scc_pkg::*;

	// One expected or observed result: a node listed in one component.
	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [COMP_W-1:0] comp;
		logic              comp_end;
		logic              run_end;
	} member_t;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [NODE_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [REQ_W-1:0] req_type = REQ_ADD;
	logic [NODE_W-1:0] edge_from = '0;
	logic [NODE_W-1:0] edge_to = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [NODE_W-1:0] member_node;
	logic [COMP_W-1:0] component_index;
	logic ends_component;
	logic last;

	// Predictor state: our own copy of the graph and node count.
	logic [63:0] fwd_adj [64];
	logic [63:0] rev_adj [64];
	int unsigned nodes_cfg = 64;

	member_t members_due [$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit timed_out = 1'b0;
	bit quiet = 1'b0;      // no idling in the final part of the run
	bit hold_sink = 1'b0;  // long receiver hold-off requested

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	strongly_connected_components dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .edge_from(edge_from), .edge_to(edge_to),
		.out_valid(out_valid), .out_ready(out_ready),
		.member_node(member_node), .component_index(component_index),
		.ends_component(ends_component), .last(last)
	);

	// Kosaraju prediction: forward DFS for finish order, reverse DFS per component.
	task automatic predict_components();
		int unsigned n;
		logic [63:0] mask, seen, cand;
		int stk [64];
		int fin [64];
		int depth, nfin, top, j, comp, first, idx;
		member_t m;
		n = (nodes_cfg > 64) ? 64 : nodes_cfg;
		mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
		seen = '0;
		nfin = 0;
		for (int i = 0; i < n; i++) begin
			if (seen[i]) continue;
			seen[i] = 1'b1;
			stk[0] = i;
			depth = 1;
			while (depth > 0) begin
				top = stk[depth-1];
				cand = fwd_adj[top] & mask & ~seen;
				if (cand != 0) begin
					j = 0;
					while (!cand[j]) j++;
					seen[j] = 1'b1;
					stk[depth++] = j;
				end else begin
					depth--;
					fin[nfin++] = top;
				end
			end
		end
		seen = '0;
		comp = 0;
		first = members_due.size();
		while (nfin > 0) begin
			top = fin[--nfin];
			if (seen[top]) continue;
			seen[top] = 1'b1;
			stk[0] = top;
			depth = 1;
			m = '{node: NODE_W'(top + 1), comp: comp[5:0], comp_end: 1'b0, run_end: 1'b0};
			members_due = {members_due, m};
			while (depth > 0) begin
				top = stk[depth-1];
				cand = rev_adj[top] & mask & ~seen;
				if (cand != 0) begin
					j = 0;
					while (!cand[j]) j++;
					seen[j] = 1'b1;
					stk[depth++] = j;
					m = '{node: NODE_W'(j + 1), comp: comp[5:0], comp_end: 1'b0,
						run_end: 1'b0};
					members_due = {members_due, m};
				end else begin
					depth--;
				end
			end
			idx = members_due.size() - 1;
			members_due[idx].comp_end = 1'b1;
			comp++;
		end
		if (members_due.size() > first)
			members_due[members_due.size()-1].run_end = 1'b1;
	endtask

	// Sender gap: now and then, in_valid drops for a random idle burst.
	task automatic sender_gap();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// Offer one request and wait for its transfer, then update the predictor.
	// in_valid stays up after the transfer so the next request can follow
	// directly; whoever waits afterwards drops it first.
	task automatic send_request(input logic [REQ_W-1:0] kind, input logic [NODE_W-1:0] src,
			input logic [NODE_W-1:0] dst);
		int unsigned n;
		sender_gap();
		in_valid <= 1'b1;
		req_type <= kind;
		edge_from <= src;
		edge_to <= dst;
		do @(posedge clk); while (!in_ready);
		n = (nodes_cfg > 64) ? 64 : nodes_cfg;
		case (kind)
			REQ_ADD: begin
				if (src >= 1 && src <= n && dst >= 1 && dst <= n) begin
					fwd_adj[src-1][dst-1] = 1'b1;
					rev_adj[dst-1][src-1] = 1'b1;
				end
			end
			REQ_CLEAR: begin
				foreach (fwd_adj[i]) begin
					fwd_adj[i] = '0;
					rev_adj[i] = '0;
				end
			end
			REQ_RUN: predict_components();
			default: ;
		endcase
	endtask

	// Wait for all results, then settle before a register write.
	task automatic drain();
		in_valid <= 1'b0;
		while (members_due.size() != 0) @(posedge clk);
		repeat (700) @(posedge clk);
	endtask

	task automatic write_node_count(input int unsigned value);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value[NODE_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		nodes_cfg = value & 32'h7f;
	endtask

	task automatic add_edge(input int unsigned src, input int unsigned dst);
		send_request(REQ_ADD, src[NODE_W-1:0], dst[NODE_W-1:0]);
	endtask

	task automatic run_search();
		send_request(REQ_RUN, NODE_W'($urandom), NODE_W'($urandom));
	endtask

	task automatic clear_graph();
		send_request(REQ_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
	endtask

	// Directed: empty graph, cycles, full range nodes, out-of-range and
	// duplicate edges, unused request code, oversized and zero node counts.
	task automatic test_directed();
		run_search();               // all 64 nodes, each its own component
		add_edge(1, 64);
		add_edge(64, 1);
		add_edge(64, 1);            // duplicate
		add_edge(0, 5);             // node zero is ignored
		add_edge(3, 65);            // beyond node_count
		add_edge(127, 127);
		add_edge(2, 3);
		add_edge(3, 2);
		add_edge(5, 5);             // self loop
		send_request(REQ_UNUSED, 7'd4, 7'd4); // unused code is ignored
		run_search();
		write_node_count(5);
		add_edge(5, 1);
		add_edge(1, 6);             // node 6 is unused now
		run_search();
		write_node_count(127);      // acts as 64
		run_search();
		write_node_count(0);
		run_search();               // no results
		write_node_count(1);
		add_edge(1, 1);
		run_search();
		clear_graph();
		write_node_count(64);
		run_search();
	endtask

	// Random graphs: mostly small node counts, random edges inside range,
	// some noise edges and clears; a few full-size runs.
	task automatic test_random_graphs();
		int unsigned n, edges;
		for (int g = 0; g < 12; g++) begin
			n = (g % 5 == 4) ? 64 : $urandom_range(1, 12);
			write_node_count(n);
			if ($urandom_range(0, 2) != 0) clear_graph();
			edges = $urandom_range(2, 7);
			for (int e = 0; e < edges; e++) begin
				if ($urandom_range(0, 7) == 0)
					send_request(REQ_ADD, NODE_W'($urandom), NODE_W'($urandom));
				else
					add_edge($urandom_range(1, n), $urandom_range(1, n));
			end
			run_search();
		end
	endtask

	// Receiver holds off while the sender keeps offering runs, so the block
	// stalls its input; then the sender waits for every result.
	task automatic test_backpressure();
		write_node_count(10);
		for (int e = 0; e < 12; e++) add_edge($urandom_range(1, 10), $urandom_range(1, 10));
		hold_sink = 1'b1;
		run_search();
		run_search();
		run_search();
		hold_sink = 1'b0;
		in_valid <= 1'b0;
		while (members_due.size() != 0) @(posedge clk);
		run_search();
	endtask

	// Final part with no idling on either side.
	task automatic test_steady_stream();
		quiet = 1'b1;
		write_node_count(64);
		clear_graph();
		for (int e = 0; e < 16; e++) add_edge($urandom_range(1, 64), $urandom_range(1, 64));
		run_search();
		write_node_count(8);
		for (int e = 0; e < 8; e++) add_edge($urandom_range(1, 8), $urandom_range(1, 8));
		run_search();
	endtask

	// Receiver: random stall bursts, a long counted hold-off on request.
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				out_ready <= 1'b0;
				hold = 0;
				while (hold < 3000) begin
					@(posedge clk);
					hold++;
				end
				out_ready <= 1'b1;
				@(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// Result checker: compare each transfer with the oldest expectation.
	always @(posedge clk) begin
		member_t want;
		if (arst_n && out_valid && out_ready) begin
			if (members_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result node=%0d comp=%0d", member_node,
						component_index);
			end else begin
				want = members_due.pop_front();
				if (want.node !== member_node || want.comp !== component_index ||
						want.comp_end !== ends_component || want.run_end !== last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp node=%0d comp=%0d end=%0d last=%0d %s %0d %0d %0d %0d",
							want.node, want.comp, want.comp_end, want.run_end, "got",
							member_node, component_index, ends_component, last);
				end
			end
		end
	end

	// Watchdog: cycles without any transfer.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		foreach (fwd_adj[i]) begin
			fwd_adj[i] = '0;
			rev_adj[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_graphs();
		test_backpressure();
		test_steady_stream();
		in_valid <= 1'b0;
		while (members_due.size() != 0) @(posedge clk);
		repeat (700) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
